// ===== src/asf_pkg.sv =====
package asf_pkg;

   localparam int MAX_ORDER_DEF   = 20;
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int COEF_BITS_DEF   = 18;
   localparam int FRAC_BITS       = 16;

   localparam int IDX_BITS   = 5;
   localparam int ORDER_BITS = 5;
   localparam int BURN_BITS  = 11;
   localparam int CSR_DATA_BITS = 11;
   localparam int CSR_IDX_BITS  = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FILTER_ORDER = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BURN_LENGTH  = 1'd1;

   localparam logic KIND_COEF   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef struct packed {
      logic load;
      logic tap_valid;
   } mac_ctrl_type;

endpackage

// ===== src/asf_vram.sv =====
module asf_vram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 20
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      clear,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (clear) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== src/asf_mac.sv =====
module asf_mac #(
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  asf_pkg::mac_ctrl_type         ctrl,
   input  logic signed [SAMPLE_BITS-1:0] innovation,
   input  logic signed [COEF_BITS-1:0]   coef,
   input  logic signed [SAMPLE_BITS-1:0] hist,
   output logic [SAMPLE_BITS-1:0]        sample,
   output logic                          saturated
);
   import asf_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_W  = PROD_W + 8;
   localparam int SH_W   = ACC_W - FRAC_BITS;
   localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_BITS - 1);

   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_vld_ff;
   logic [ACC_W-1:0]         acc_ff;
   logic [ACC_W-1:0]         rnd_sum;
   logic [SH_W-1:0]          shifted;
   logic [SH_W-SAMPLE_BITS:0] upper;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(coef) * PROD_W'(hist);
      if (ctrl.load) begin
         acc_ff <= {{(ACC_W-SAMPLE_BITS-FRAC_BITS){innovation[SAMPLE_BITS-1]}},
                    innovation, {FRAC_BITS{1'b0}}};
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.tap_valid;
      end
   end

   always_comb begin
      rnd_sum = acc_ff + HALF_LSB;
      shifted = rnd_sum[ACC_W-1:FRAC_BITS];
      upper   = shifted[SH_W-1:SAMPLE_BITS-1];
      if ((upper == '0) || (upper == '1)) begin
         sample    = shifted[SAMPLE_BITS-1:0];
         saturated = 1'b0;
      end else begin
         sample    = {shifted[SH_W-1], {(SAMPLE_BITS-1){~shifted[SH_W-1]}}};
         saturated = 1'b1;
      end
   end

endmodule

// ===== src/autoregressive_synthesis_filter.sv =====
// Channel | Dir | tdata (low bit up)                         | tuser (low bit up)
// req     | in  | coef_index, coef_value, innovation, zeros  | kind, series_start
// rsp     | out | sample, zeros                              | saturated
// csr     | in  | csr_wr_en, csr_index, csr_wr_data (write only, no read-back)
//
// A coefficient is written when accepted. A sample passes through accept, one
// tap per cycle, pipeline drain in DRAIN1 and DRAIN2, and write-back; order zero
// goes from accept straight to write-back. One multiply-accumulate sets the rate,
// walking the taps through the coefficient and history memory read ports.
// Reset is synchronous, active high, and clears all valid bits at once.
// A result waiting in the output register stalls only the write-back cycle.
module autoregressive_synthesis_filter #(
   parameter int MAX_ORDER   = asf_pkg::MAX_ORDER_DEF,
   parameter int SAMPLE_BITS = asf_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = asf_pkg::COEF_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // coef_index, coef_value, innovation, zero fill
   input  logic [((asf_pkg::IDX_BITS+COEF_BITS+SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // kind, series_start
   input  logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // sample, zero fill
   output logic [((SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   // saturated
   output logic [0:0] rsp_tuser,
   input  logic csr_wr_en,
   input  logic [asf_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [asf_pkg::CSR_DATA_BITS-1:0] csr_wr_data
);
   import asf_pkg::*;

   localparam int PTR_W      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int ORD_W      = $clog2(MAX_ORDER + 1);
   localparam int OUT_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ISSUE  = 5'b00010,
      ST_DRAIN1 = 5'b00100,
      ST_DRAIN2 = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [ORDER_BITS-1:0]  filter_order_ff;
   logic [BURN_BITS-1:0]   burn_length_ff;
   logic [PTR_W-1:0]       ring_ptr_ff, ring_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]       tap_ff, tap_in;
   logic [BURN_BITS-1:0]   discard_ff, discard_in;
   logic                   pass_ff, pass_in;
   logic                   tap_vld_ff;
   logic [SAMPLE_BITS-1:0] innov_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                   rsp_sat_ff;

   logic [IDX_BITS-1:0]           in_coef_index;
   logic signed [COEF_BITS-1:0]   in_coef_value;
   logic signed [SAMPLE_BITS-1:0] in_innovation;
   logic                          in_kind;
   logic                          in_series_start;

   logic                          accept;
   logic                          coef_wr;
   logic                          sample_acc;
   logic                          hist_clear;
   logic [ORD_W-1:0]              order;
   logic                          last_tap;
   logic [PTR_W-1:0]              base_ptr;
   logic                          finish_ok;
   logic                          emit;
   logic [SAMPLE_BITS-1:0]        result;
   logic                          result_sat;
   logic                          hist_wr;
   logic                          issue;
   logic signed [COEF_BITS-1:0]   coef_rd;
   logic signed [SAMPLE_BITS-1:0] hist_rd;
   logic [SAMPLE_BITS-1:0]        mac_sample;
   logic                          mac_sat;
   mac_ctrl_type                  mac_ctrl;

   assign in_coef_index   = req_tdata[IDX_BITS-1:0];
   assign in_coef_value   = req_tdata[IDX_BITS +: COEF_BITS];
   assign in_innovation   = req_tdata[IDX_BITS+COEF_BITS +: SAMPLE_BITS];
   assign in_kind         = req_tuser[0];
   assign in_series_start = req_tuser[1];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign coef_wr    = accept && (in_kind == KIND_COEF) && (int'(in_coef_index) < MAX_ORDER);
   assign sample_acc = accept && (in_kind == KIND_SAMPLE);
   assign hist_clear = sample_acc && in_series_start;

   assign order    = (int'(filter_order_ff) > MAX_ORDER) ? ORD_W'(MAX_ORDER)
                                                         : ORD_W'(filter_order_ff);
   assign last_tap = (ORD_W'(tap_ff) + ORD_W'(1)) == order;
   assign base_ptr = in_series_start ? '0 : ring_ptr_ff;
   assign issue    = (state_ff == ST_ISSUE);

   assign finish_ok  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);
   assign emit       = pass_ff || !(discard_ff < burn_length_ff);
   assign result     = pass_ff ? innov_ff : mac_sample;
   assign result_sat = pass_ff ? 1'b0 : mac_sat;
   assign hist_wr    = finish_ok && !pass_ff;

   assign mac_ctrl.load      = sample_acc;
   assign mac_ctrl.tap_valid = tap_vld_ff;

   always_comb begin
      state_in    = state_ff;
      ring_ptr_in = ring_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      tap_in      = tap_ff;
      discard_in  = discard_ff;
      pass_in     = pass_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (sample_acc) begin
               if (in_series_start) begin
                  ring_ptr_in = '0;
                  discard_in  = '0;
               end
               rd_ptr_in = (base_ptr == '0) ? PTR_W'(MAX_ORDER - 1) : base_ptr - PTR_W'(1);
               tap_in    = '0;
               if (order == '0) begin
                  pass_in  = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  pass_in  = 1'b0;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            tap_in    = tap_ff + PTR_W'(1);
            rd_ptr_in = (rd_ptr_ff == '0) ? PTR_W'(MAX_ORDER - 1) : rd_ptr_ff - PTR_W'(1);
            if (last_tap) begin
               state_in = ST_DRAIN1;
            end
         end
         ST_DRAIN1: begin
            state_in = ST_DRAIN2;
         end
         ST_DRAIN2: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (finish_ok) begin
               state_in = ST_IDLE;
               if (!pass_ff) begin
                  ring_ptr_in = (ring_ptr_ff == PTR_W'(MAX_ORDER - 1)) ? '0
                                                                      : ring_ptr_ff + PTR_W'(1);
                  if (discard_ff < burn_length_ff) begin
                     discard_in = discard_ff + BURN_BITS'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish_ok && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         filter_order_ff <= '0;
         burn_length_ff  <= '0;
         ring_ptr_ff     <= '0;
         rd_ptr_ff       <= '0;
         tap_ff          <= '0;
         discard_ff      <= '0;
         pass_ff         <= 1'b0;
         tap_vld_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ring_ptr_ff  <= ring_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         tap_ff       <= tap_in;
         discard_ff   <= discard_in;
         pass_ff      <= pass_in;
         tap_vld_ff   <= issue;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_FILTER_ORDER: filter_order_ff <= csr_wr_data[ORDER_BITS-1:0];
               CSR_BURN_LENGTH:  burn_length_ff  <= csr_wr_data[BURN_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sample_acc) begin
         innov_ff <= in_innovation;
      end
      if (finish_ok && emit) begin
         rsp_sample_ff <= result;
         rsp_sat_ff    <= result_sat;
      end
   end

   asf_vram #(
      .WIDTH (COEF_BITS),
      .DEPTH (MAX_ORDER)
   ) u_coef_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (1'b0),
      .wr_en   (coef_wr),
      .wr_addr (PTR_W'(in_coef_index)),
      .wr_data (in_coef_value),
      .rd_en   (issue),
      .rd_addr (tap_ff),
      .rd_data (coef_rd)
   );

   asf_vram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_ORDER)
   ) u_hist_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (hist_clear),
      .wr_en   (hist_wr),
      .wr_addr (ring_ptr_ff),
      .wr_data (result),
      .rd_en   (issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (hist_rd)
   );

   asf_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .innovation (in_innovation),
      .coef       (coef_rd),
      .hist       (hist_rd),
      .sample     (mac_sample),
      .saturated  (mac_sat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_DATA_W'(rsp_sample_ff);
   assign rsp_tuser  = rsp_sat_ff;

endmodule
